// ===== rtl/ilir_pkg.sv =====
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types, codes and default sizes for the indexed list block.
// ----------------------------------------------------------------------------
package ilir_pkg;

   // Defaults for the top-level parameters
   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   // Fixed field widths of the channels
   localparam int CMD_W    = 3;
   localparam int IDX_W    = 4;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 3'd0,
      CMD_WRITE  = 3'd1,
      CMD_APPEND = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_REMOVE = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK    = 2'd0,
      STS_RANGE = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_LATCH,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINAL,
      S_REPLY
   } state_type;

   typedef enum logic {
      RD_AT_INDEX,
      RD_SHIFT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_AT_INDEX,
      WR_AT_TAIL,
      WR_SHIFT
   } wr_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      logic       decode;
      logic       mem_rd;
      rd_sel_type rd_sel;
      logic       mem_wr;
      wr_sel_type wr_sel;
      logic       ptr_load_tail;
      logic       ptr_load_index;
      logic       ptr_step;
      logic       data_latch;
      logic       count_inc;
      logic       count_dec;
      logic       rsp_load;
   } ctl_type;

   // Datapath to controller
   typedef struct packed {
      cmd_type    cmd;
      status_type status;
      logic       shift_more;
   } stat_type;

endpackage

// ===== rtl/ilir_if.sv =====
// ----------------------------------------------------------------------------
// ilir_req_if / ilir_rsp_if
// Valid/ready channels carrying list commands and their results.
// ----------------------------------------------------------------------------
interface ilir_req_if;
   logic                                valid;
   logic                                ready;
   logic        [ilir_pkg::CMD_W-1:0]   command;
   logic        [ilir_pkg::IDX_W-1:0]   index;
   logic signed [ilir_pkg::VALUE_W-1:0] value;

   modport source (output valid, output command, output index, output value, input ready);
   modport sink   (input valid, input command, input index, input value, output ready);
endinterface

interface ilir_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ilir_pkg::VALUE_W-1:0]  data_out;
   logic        [ilir_pkg::COUNT_W-1:0]  count;
   logic        [ilir_pkg::STATUS_W-1:0] status;

   modport source (output valid, output data_out, output count, output status, input ready);
   modport sink   (input valid, input data_out, input count, input status, output ready);
endinterface

// ===== rtl/ilir_datapath.sv =====
// ----------------------------------------------------------------------------
// ilir_datapath
// Entry memory, entry count, shift pointer and result registers.
// ----------------------------------------------------------------------------
module ilir_datapath #(
   parameter int DEPTH      = ilir_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ilir_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic        [ilir_pkg::CMD_W-1:0]    req_command,
   input  logic        [ilir_pkg::IDX_W-1:0]    req_index,
   input  logic signed [ilir_pkg::VALUE_W-1:0]  req_value,
   input  ilir_pkg::ctl_type                    ctl,
   output ilir_pkg::stat_type                   stat,
   output logic signed [ilir_pkg::VALUE_W-1:0]  rsp_data_out,
   output logic        [ilir_pkg::COUNT_W-1:0]  rsp_count,
   output logic        [ilir_pkg::STATUS_W-1:0] rsp_status
);

   localparam int VW     = ilir_pkg::VALUE_W;
   localparam int IW     = ilir_pkg::IDX_W;
   localparam int CW     = ilir_pkg::COUNT_W;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > IW) ? CNT_W : IW;
   localparam int EXT_W  = VW + DATA_WIDTH;
   localparam int CEXT_W = CNT_W + CW;

   logic [DATA_WIDTH-1:0] mem [DEPTH];

   ilir_pkg::cmd_type    cmd_ff;
   logic [IW-1:0]        idx_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [CNT_W-1:0]     ptr_ff;
   logic [CNT_W-1:0]     ptr_in;
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic [DATA_WIDTH-1:0] res_data_ff;
   ilir_pkg::status_type res_status_ff;
   logic signed [VW-1:0] rsp_data_ff;
   logic [CW-1:0]        rsp_count_ff;
   ilir_pkg::status_type rsp_status_ff;

   logic [CMP_W-1:0]     idx_wide;
   logic [CMP_W-1:0]     count_wide;
   logic [CMP_W-1:0]     ptr_wide;
   logic                 idx_ok;
   logic                 full;
   logic                 shift_up;
   logic [CNT_W-1:0]     ptr_dec;
   logic [CNT_W-1:0]     ptr_inc;
   logic [CNT_W-1:0]     ptr_next;
   logic [ADDR_W-1:0]    idx_addr;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   ilir_pkg::status_type status_now;
   logic signed [EXT_W-1:0] val_ext;
   logic signed [EXT_W-1:0] data_ext;
   logic [CEXT_W-1:0]    count_ext;

   assign idx_wide   = CMP_W'(idx_ff);
   assign count_wide = CMP_W'(count_ff);
   assign ptr_wide   = CMP_W'(ptr_ff);
   assign idx_ok     = idx_wide < count_wide;
   assign full       = count_ff == CNT_W'(DEPTH);
   assign shift_up   = cmd_ff == ilir_pkg::CMD_INSERT;
   assign ptr_dec    = ptr_ff - CNT_W'(1);
   assign ptr_inc    = ptr_ff + CNT_W'(1);
   assign ptr_next   = shift_up ? ptr_dec : ptr_inc;
   assign idx_addr   = idx_wide[ADDR_W-1:0];

   // Insert walks down to the index, remove walks up to the tail
   assign stat.cmd        = cmd_ff;
   assign stat.status     = status_now;
   assign stat.shift_more = shift_up ? (ptr_wide != idx_wide) : (ptr_inc != count_ff);

   always_comb begin
      status_now = ilir_pkg::STS_OK;
      case (cmd_ff)
         ilir_pkg::CMD_READ,
         ilir_pkg::CMD_WRITE,
         ilir_pkg::CMD_REMOVE: begin
            if (!idx_ok) status_now = ilir_pkg::STS_RANGE;
         end
         ilir_pkg::CMD_APPEND: begin
            if (full) status_now = ilir_pkg::STS_FULL;
         end
         ilir_pkg::CMD_INSERT: begin
            if (!idx_ok)   status_now = ilir_pkg::STS_RANGE;
            else if (full) status_now = ilir_pkg::STS_FULL;
         end
         default: status_now = ilir_pkg::STS_OK;
      endcase
   end

   always_comb begin
      case (ctl.rd_sel)
         ilir_pkg::RD_AT_INDEX: rd_addr = idx_addr;
         ilir_pkg::RD_SHIFT:    rd_addr = ptr_next[ADDR_W-1:0];
         default:               rd_addr = idx_addr;
      endcase
   end

   always_comb begin
      case (ctl.wr_sel)
         ilir_pkg::WR_AT_INDEX: begin
            wr_addr = idx_addr;
            wr_data = val_ff;
         end
         ilir_pkg::WR_AT_TAIL: begin
            wr_addr = count_ff[ADDR_W-1:0];
            wr_data = val_ff;
         end
         ilir_pkg::WR_SHIFT: begin
            wr_addr = ptr_ff[ADDR_W-1:0];
            wr_data = rdata_ff;
         end
         default: begin
            wr_addr = idx_addr;
            wr_data = val_ff;
         end
      endcase
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (ctl.ptr_load_tail)       ptr_in = count_ff;
      else if (ctl.ptr_load_index) ptr_in = idx_wide[CNT_W-1:0];
      else if (ctl.ptr_step)       ptr_in = ptr_next;
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.count_inc)      count_in = count_ff + CNT_W'(1);
      else if (ctl.count_dec) count_in = count_ff - CNT_W'(1);
   end

   // Sign-extend or truncate data between the channel and stored widths; zero-extend or truncate the count
   assign val_ext   = EXT_W'(req_value);
   assign data_ext  = EXT_W'($signed(res_data_ff));
   assign count_ext = CEXT_W'(count_ff);

   always_ff @(posedge clock) begin
      if (ctl.mem_wr) mem[wr_addr] <= wr_data;
      if (ctl.mem_rd) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (ctl.capture) begin
         cmd_ff      <= ilir_pkg::cmd_type'(req_command);
         idx_ff      <= req_index;
         val_ff      <= val_ext[DATA_WIDTH-1:0];
         res_data_ff <= '0;
      end else if (ctl.data_latch) begin
         res_data_ff <= rdata_ff;
      end
      if (ctl.decode) res_status_ff <= status_now;
      if (ctl.rsp_load) begin
         rsp_data_ff   <= data_ext[VW-1:0];
         rsp_count_ff  <= count_ext[CW-1:0];
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_data_out = rsp_data_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ===== rtl/ilir_controller.sv =====
// ----------------------------------------------------------------------------
// ilir_controller
// Sequencer for one transaction at a time, plus the result handshake.
// ----------------------------------------------------------------------------
module ilir_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ilir_pkg::stat_type stat,
   output ilir_pkg::ctl_type  ctl
);

   ilir_pkg::state_type state_ff;
   ilir_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilir_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctl          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ilir_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = ilir_pkg::S_DECODE;
            end
         end
         ilir_pkg::S_DECODE: begin
            ctl.decode = 1'b1;
            state_in   = ilir_pkg::S_REPLY;
            if (stat.status == ilir_pkg::STS_OK) begin
               case (stat.cmd)
                  ilir_pkg::CMD_READ: begin
                     ctl.mem_rd = 1'b1;
                     ctl.rd_sel = ilir_pkg::RD_AT_INDEX;
                     state_in   = ilir_pkg::S_LATCH;
                  end
                  ilir_pkg::CMD_WRITE: begin
                     ctl.mem_wr = 1'b1;
                     ctl.wr_sel = ilir_pkg::WR_AT_INDEX;
                  end
                  ilir_pkg::CMD_APPEND: begin
                     ctl.mem_wr    = 1'b1;
                     ctl.wr_sel    = ilir_pkg::WR_AT_TAIL;
                     ctl.count_inc = 1'b1;
                  end
                  ilir_pkg::CMD_INSERT: begin
                     ctl.ptr_load_tail = 1'b1;
                     state_in          = ilir_pkg::S_SHIFT_RD;
                  end
                  ilir_pkg::CMD_REMOVE: begin
                     ctl.mem_rd         = 1'b1;
                     ctl.rd_sel         = ilir_pkg::RD_AT_INDEX;
                     ctl.ptr_load_index = 1'b1;
                     state_in           = ilir_pkg::S_LATCH;
                  end
                  default: state_in = ilir_pkg::S_REPLY;
               endcase
            end
         end
         ilir_pkg::S_LATCH: begin
            ctl.data_latch = 1'b1;
            state_in = (stat.cmd == ilir_pkg::CMD_REMOVE) ? ilir_pkg::S_SHIFT_RD
                                                          : ilir_pkg::S_REPLY;
         end
         ilir_pkg::S_SHIFT_RD: begin
            if (stat.shift_more) begin
               ctl.mem_rd = 1'b1;
               ctl.rd_sel = ilir_pkg::RD_SHIFT;
               state_in   = ilir_pkg::S_SHIFT_WR;
            end else begin
               state_in = ilir_pkg::S_FINAL;
            end
         end
         ilir_pkg::S_SHIFT_WR: begin
            ctl.mem_wr   = 1'b1;
            ctl.wr_sel   = ilir_pkg::WR_SHIFT;
            ctl.ptr_step = 1'b1;
            state_in     = ilir_pkg::S_SHIFT_RD;
         end
         ilir_pkg::S_FINAL: begin
            if (stat.cmd == ilir_pkg::CMD_INSERT) begin
               ctl.mem_wr    = 1'b1;
               ctl.wr_sel    = ilir_pkg::WR_AT_INDEX;
               ctl.count_inc = 1'b1;
            end else begin
               ctl.count_dec = 1'b1;
            end
            state_in = ilir_pkg::S_REPLY;
         end
         ilir_pkg::S_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ilir_pkg::S_IDLE;
            end
         end
         default: state_in = ilir_pkg::S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/indexed_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Fixed-capacity ordered list with read, write, append, insert and remove.
// ----------------------------------------------------------------------------
// The list holds up to DEPTH signed words in a single-port-per-direction
// memory (one write and one registered read a cycle) and takes one
// transaction at a time; every transaction returns exactly one result with
// the word read or removed, the entry count afterwards and a status. The
// cost of a transaction is set by the memory walk that moves the entries:
// write, append, an out-of-range index, a full list or an unused command
// go straight from decode to the result, read adds a latch step, insert
// walks down from the tail to the index and remove walks up to the tail,
// each moved entry taking a read and a write state. A stalled result adds
// the stall time. A new transaction is accepted while the previous
// result still waits on the result channel.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove #(
   parameter int DEPTH      = ilir_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ilir_pkg::DATA_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   ilir_req_if.sink   req_bus,
   ilir_rsp_if.source rsp_bus
);

   ilir_pkg::ctl_type  ctl;
   ilir_pkg::stat_type stat;

   // Sequence the transaction: decode, memory walk, result hand-off
   ilir_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Hold the entries, the count and the result payload
   ilir_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_command  (req_bus.command),
      .req_index    (req_bus.index),
      .req_value    (req_bus.value),
      .ctl          (ctl),
      .stat         (stat),
      .rsp_data_out (rsp_bus.data_out),
      .rsp_count    (rsp_bus.count),
      .rsp_status   (rsp_bus.status)
   );

endmodule

// ===== rtl/ilir_checker.sv =====
// ----------------------------------------------------------------------------
// ilir_checker
// Port-level assertions for the indexed list, bound to the top level.
// ----------------------------------------------------------------------------
module ilir_checker #(
   parameter int DEPTH = ilir_pkg::DEPTH_DEFAULT
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [ilir_pkg::VALUE_W-1:0]  rsp_data_out,
   input logic        [ilir_pkg::COUNT_W-1:0]  rsp_count,
   input logic        [ilir_pkg::STATUS_W-1:0] rsp_status
);

   localparam int CW = ilir_pkg::COUNT_W;
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out))
      else $error("result dropped or changed while stalled");

   // Drop the data word on any failed transaction
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ilir_pkg::STS_OK) |-> rsp_data_out == '0)
      else $error("failed transaction returned non-zero data");

   // A full status reports a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ilir_pkg::STS_FULL) |-> rsp_count == FULL_COUNT)
      else $error("full status with count below capacity");

   // One transaction in flight: no acceptance right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted a transaction while one is in progress");

endmodule

bind indexed_list_insert_remove ilir_checker #(
   .DEPTH (DEPTH)
) u_ilir_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_data_out (rsp_bus.data_out),
   .rsp_count    (rsp_bus.count),
   .rsp_status   (rsp_bus.status)
);
